// ===== design/aspf_pkg.sv =====
// ----------------------------------------------------------------------------
// Attitude sentence field parser package
// Shared widths, character codes and types for the parser and its fields.
// ----------------------------------------------------------------------------
`default_nettype none

package aspf_pkg;

  localparam int BYTE_W          = 8;
  localparam int MAG_W           = 20;
  localparam int VALUE_W         = 21;
  localparam int COMMA_W         = 4;
  localparam int FIELD_CHARS_DEF = 6;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2c;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2a;

  localparam logic [COMMA_W-1:0] COMMA_MAX   = 4'd15;
  localparam logic [COMMA_W-1:0] COMMA_YAW   = 4'd1;
  localparam logic [COMMA_W-1:0] COMMA_PITCH = 4'd3;
  localparam logic [COMMA_W-1:0] COMMA_ROLL  = 4'd5;

  typedef struct packed {
    logic clear;
    logic take;
  } field_ctl_t;

endpackage

`default_nettype wire

// ===== design/aspf_if.sv =====
// ----------------------------------------------------------------------------
// Attitude sentence field parser channels
// Byte request channel and attitude result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aspf_byte_if;
  logic                         valid;
  logic                         ready;
  logic [aspf_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface aspf_att_if;
  logic                                valid;
  logic                                ready;
  logic signed [aspf_pkg::VALUE_W-1:0] yaw_value;
  logic signed [aspf_pkg::VALUE_W-1:0] pitch_value;
  logic signed [aspf_pkg::VALUE_W-1:0] roll_value;
  logic                                yaw_present;
  logic                                pitch_present;
  logic                                roll_present;

  modport source (output valid, output yaw_value, output pitch_value, output roll_value,
                  output yaw_present, output pitch_present, output roll_present,
                  input ready);
  modport sink   (input valid, input yaw_value, input pitch_value, input roll_value,
                  input yaw_present, input pitch_present, input roll_present,
                  output ready);
endinterface

`default_nettype wire

// ===== design/aspf_field.sv =====
// ----------------------------------------------------------------------------
// Attitude sentence field accumulator
// Converts one comma-delimited field to a signed integer, character by character.
// ----------------------------------------------------------------------------
`default_nettype none

module aspf_field #(
  parameter int FIELD_CHARS = aspf_pkg::FIELD_CHARS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire aspf_pkg::field_ctl_t                ctl,
  input  wire logic [aspf_pkg::BYTE_W-1:0]         rx_byte,
  output      logic signed [aspf_pkg::VALUE_W-1:0] value,
  output      logic                                present
);

  localparam int CNT_W = $clog2(FIELD_CHARS + 1);
  localparam logic [aspf_pkg::BYTE_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [aspf_pkg::BYTE_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [aspf_pkg::BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [aspf_pkg::BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [aspf_pkg::BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [aspf_pkg::BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [aspf_pkg::BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                      phase, phase_next;
  logic [aspf_pkg::MAG_W-1:0]  magnitude, magnitude_next;
  logic                        negative, negative_next;
  logic [CNT_W-1:0]            char_count;

  logic                        is_space;
  logic                        is_digit;
  logic                        room;
  logic [aspf_pkg::MAG_W-1:0]  mag_x10;
  logic [aspf_pkg::MAG_W-1:0]  mag_acc;

  assign is_space = (rx_byte == CH_SPACE) || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign room     = char_count < CNT_W'(FIELD_CHARS);
  assign mag_x10  = (magnitude << 3) + (magnitude << 1);
  assign mag_acc  = mag_x10 + aspf_pkg::MAG_W'(rx_byte[3:0]);

  always_comb begin
    phase_next     = phase;
    magnitude_next = magnitude;
    negative_next  = negative;
    unique case (phase)
      PH_SKIP: begin
        if (is_space) begin
          phase_next = PH_SKIP;
        end else if (rx_byte == CH_PLUS) begin
          phase_next = PH_DIGITS;
        end else if (rx_byte == CH_MINUS) begin
          phase_next    = PH_DIGITS;
          negative_next = 1'b1;
        end else if (is_digit) begin
          phase_next     = PH_DIGITS;
          magnitude_next = mag_acc;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          magnitude_next = mag_acc;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      phase      <= PH_SKIP;
      magnitude  <= '0;
      negative   <= 1'b0;
      char_count <= '0;
    end else if (ctl.take && room) begin
      phase      <= phase_next;
      magnitude  <= magnitude_next;
      negative   <= negative_next;
      char_count <= char_count + CNT_W'(1);
    end
  end

  assign value   = negative ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});
  assign present = char_count != '0;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_W'(FIELD_CHARS))
    else $error("field character count beyond limit");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    ctl.take && !ctl.clear && !room |=> $stable(char_count) && $stable(magnitude))
    else $error("field updated past its character limit");

endmodule

`default_nettype wire

// ===== design/attitude_sentence_field_parser_unit.sv =====
// A '*' byte accepted into the input register then raises valid in the result register.
// Throughput: one byte per cycle; a held result stalls input only when the next '*' arrives.
// Input register holds the byte channel's data; result register holds the field values.
// Reset (synchronous, active high) clears sentence state, all fields and both valids.
// ----------------------------------------------------------------------------
// Attitude sentence field parser unit
// Parses yaw, pitch and roll from a heading-pitch-roll sentence, one byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module attitude_sentence_field_parser_unit #(
  parameter int FIELD_CHARS = aspf_pkg::FIELD_CHARS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  aspf_byte_if.sink rx,
  aspf_att_if.source att
);

  logic                           s_valid;
  logic [aspf_pkg::BYTE_W-1:0]    s_byte;
  logic                           in_sentence;
  logic [aspf_pkg::COMMA_W-1:0]   comma_count;

  logic                           is_dollar;
  logic                           is_star;
  logic                           is_comma;
  logic                           emits;
  logic                           consume;

  aspf_pkg::field_ctl_t           ctl_yaw, ctl_pitch, ctl_roll;
  logic signed [aspf_pkg::VALUE_W-1:0] val_yaw, val_pitch, val_roll;
  logic                           pr_yaw, pr_pitch, pr_roll;
  logic                           data_char;
  logic                           clear_all;

  assign is_dollar = s_byte == aspf_pkg::CH_DOLLAR;
  assign is_star   = s_byte == aspf_pkg::CH_STAR;
  assign is_comma  = s_byte == aspf_pkg::CH_COMMA;
  assign emits     = in_sentence && is_star && !is_dollar;
  assign consume   = s_valid && (!emits || !att.valid || att.ready);
  assign rx.ready  = !s_valid || consume;

  assign clear_all = consume && (is_dollar || emits);
  assign data_char = consume && in_sentence && !is_dollar && !is_star && !is_comma;

  assign ctl_yaw   = '{clear: clear_all, take: data_char && comma_count == aspf_pkg::COMMA_YAW};
  assign ctl_pitch = '{clear: clear_all,
                       take: data_char && comma_count == aspf_pkg::COMMA_PITCH};
  assign ctl_roll  = '{clear: clear_all, take: data_char && comma_count == aspf_pkg::COMMA_ROLL};

  aspf_field #(.FIELD_CHARS(FIELD_CHARS)) u_yaw (
    .clk(clk), .rst(rst), .ctl(ctl_yaw), .rx_byte(s_byte), .value(val_yaw), .present(pr_yaw)
  );

  aspf_field #(.FIELD_CHARS(FIELD_CHARS)) u_pitch (
    .clk(clk), .rst(rst), .ctl(ctl_pitch), .rx_byte(s_byte), .value(val_pitch),
    .present(pr_pitch)
  );

  aspf_field #(.FIELD_CHARS(FIELD_CHARS)) u_roll (
    .clk(clk), .rst(rst), .ctl(ctl_roll), .rx_byte(s_byte), .value(val_roll), .present(pr_roll)
  );

  // hold incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (rx.ready) begin
      s_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      s_byte <= rx.rx_byte;
    end
  end

  // advance sentence state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      comma_count <= '0;
    end else if (consume) begin
      if (is_dollar) begin
        in_sentence <= 1'b1;
        comma_count <= '0;
      end else if (emits) begin
        in_sentence <= 1'b0;
        comma_count <= '0;
      end else if (in_sentence && is_comma && comma_count != aspf_pkg::COMMA_MAX) begin
        comma_count <= comma_count + aspf_pkg::COMMA_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      att.valid <= 1'b0;
    end else if (consume && emits) begin
      att.valid <= 1'b1;
    end else if (att.ready) begin
      att.valid <= 1'b0;
    end
    if (consume && emits) begin
      att.yaw_value     <= val_yaw;
      att.pitch_value   <= val_pitch;
      att.roll_value    <= val_roll;
      att.yaw_present   <= pr_yaw;
      att.pitch_present <= pr_pitch;
      att.roll_present  <= pr_roll;
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    consume && emits |=> att.valid)
    else $error("sentence end did not raise result valid");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    consume && emits |=> !in_sentence && comma_count == '0)
    else $error("sentence state not cleared after result");

  a_comma_step: assert property (@(posedge clk) disable iff (rst)
    consume && in_sentence && is_comma && comma_count != aspf_pkg::COMMA_MAX
    |=> comma_count == $past(comma_count) + aspf_pkg::COMMA_W'(1))
    else $error("comma count did not advance");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> s_valid && emits && att.valid && !att.ready)
    else $error("input stalled without a pending result");

  a_idle_no_field: assert property (@(posedge clk) disable iff (rst)
    !in_sentence |-> !ctl_yaw.take && !ctl_pitch.take && !ctl_roll.take)
    else $error("field taken outside a sentence");

endmodule

`default_nettype wire
